// ===== sv/adsr_pkg.sv =====
// Shared types, widths, codes and reset values of the ADSR envelope generator.
package adsr_pkg;

    // Field and register widths.
    localparam int SINCE_W    = 32;
    localparam int UNTIL_W    = 32;
    localparam int LEN_W      = 24;
    localparam int LEVEL_W    = 31;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int PROD_W     = 2 * LEVEL_W;

    // Default number of fractional bits of the level format.
    localparam int DEFAULT_LEVEL_FRAC_BITS = 31;

    // Level constants shared by every format.
    localparam logic [LEVEL_W-1:0] ENV_FLOOR  = 31'h0000_1000;
    localparam logic [LEVEL_W-1:0] ENV_CUTOFF = 31'h0000_0400;

    // Register reset values.
    localparam logic [LEN_W-1:0]   ATTACK_RESET  = 24'd480;
    localparam logic [LEN_W-1:0]   DECAY_RESET   = 24'd4800;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RESET = 31'd1610612736;
    localparam logic [LEVEL_W-1:0] RELEASE_RESET = 31'd2130000000;

    // Envelope phase codes.
    typedef enum logic [PHASE_W-1:0] {
        PHASE_ATTACK  = 2'd0,
        PHASE_DECAY   = 2'd1,
        PHASE_SUSTAIN = 2'd2,
        PHASE_RELEASE = 2'd3
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_LENGTH       = 2'd0,
        CFG_DECAY_LENGTH        = 2'd1,
        CFG_SUSTAIN_LEVEL       = 2'd2,
        CFG_RELEASE_COEFFICIENT = 2'd3
    } cfg_idx_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [LEN_W-1:0]   attack_length;
        logic [LEN_W-1:0]   decay_length;
        logic [LEVEL_W-1:0] hold_level;
        logic [LEVEL_W-1:0] release_coefficient;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic classify;
        logic multiply;
        logic div_init;
        logic div_step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
    } status_t;

endpackage

// ===== sv/adsr_cfg.sv =====
// Configuration register bank of the ADSR envelope generator.
module adsr_cfg
    import adsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [LEN_W-1:0]   attack_reg;
    logic [LEN_W-1:0]   decay_reg;
    logic [LEVEL_W-1:0] sustain_reg;
    logic [LEVEL_W-1:0] release_reg;

    // Register writes, decoded by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= ATTACK_RESET;
            decay_reg   <= DECAY_RESET;
            sustain_reg <= SUSTAIN_RESET;
            release_reg <= RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ATTACK_LENGTH:       attack_reg  <= cfg_data[LEN_W-1:0];
                CFG_DECAY_LENGTH:        decay_reg   <= cfg_data[LEN_W-1:0];
                CFG_SUSTAIN_LEVEL:       sustain_reg <= cfg_data[LEVEL_W-1:0];
                CFG_RELEASE_COEFFICIENT: release_reg <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.attack_length       = attack_reg;
    assign cfg.decay_length        = decay_reg;
    assign cfg.hold_level          = sustain_reg;
    assign cfg.release_coefficient = release_reg;

endmodule

// ===== sv/adsr_ctrl.sv =====
// Sequencing state machine of the ADSR envelope generator.
module adsr_ctrl
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = DEFAULT_LEVEL_FRAC_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int CNT_W = $clog2(LEVEL_FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LEVEL_FRAC_BITS - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CLASS  = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_DINIT  = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             finish;

    assign accept = (state_reg == ST_IDLE) && in_valid;
    assign finish = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = status.need_div ? ST_DINIT : ST_FINISH;
            end
            ST_DINIT:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output slot fills when a result is loaded and empties when taken.
    always_comb
    begin
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Commands to the datapath.
    assign cmd.capture  = accept;
    assign cmd.classify = (state_reg == ST_CLASS);
    assign cmd.multiply = (state_reg == ST_MUL);
    assign cmd.div_init = (state_reg == ST_DINIT);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.finish   = finish;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== sv/adsr_dp.sv =====
// Datapath of the ADSR envelope generator: classify, multiply, divide, level update.
module adsr_dp
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = DEFAULT_LEVEL_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [SINCE_W-1:0] since_start,
    input  logic [UNTIL_W-1:0] until_release,
    output logic [LEVEL_W-1:0] level,
    output logic [PHASE_W-1:0] phase
);

    localparam int L = LEVEL_FRAC_BITS;
    localparam logic [LEVEL_W-1:0] ENV_FULL = LEVEL_W'((64'd1 << L) - 64'd1);

    // Captured input transaction.
    logic [SINCE_W-1:0] since_reg;
    logic [UNTIL_W-1:0] until_reg;

    // Operands chosen by classification.
    phase_t             phase_sel_reg;
    logic [LEVEL_W-1:0] mul_a_reg;
    logic [LEVEL_W-1:0] mul_b_reg;
    logic [LEN_W-1:0]   div_d_reg;
    logic [PROD_W-1:0]  prod_reg;

    // Divider state.
    logic [LEN_W-1:0] rem_reg;
    logic [L-1:0]     quo_reg;

    // Envelope state, which also serves as the output register.
    logic [LEVEL_W-1:0] cur_level_reg, cur_level_next;
    phase_t             cur_phase_reg, cur_phase_next;

    logic [LEVEL_W-1:0] sus_sat;
    logic               releasing;
    logic               in_attack;
    logic               in_decay;
    logic [SINCE_W:0]   decay_end;
    logic [LEN_W-1:0]   progress;
    logic [PROD_W-1:0]  rel_shift;
    logic [LEVEL_W-1:0] rel_level;
    logic [LEN_W:0]     partial;
    logic [LEN_W+1:0]   diff;
    logic [LEVEL_W-1:0] quo_ext;

    // Sustain saturated to the full scale of the format.
    assign sus_sat = (cfg.hold_level > ENV_FULL) ? ENV_FULL : cfg.hold_level;

    // Phase decision on the captured transaction.
    assign releasing = (until_reg == '0) || until_reg[UNTIL_W-1];
    assign decay_end = (SINCE_W+1)'(cfg.attack_length) + (SINCE_W+1)'(cfg.decay_length);
    assign in_attack = since_reg < SINCE_W'(cfg.attack_length);
    assign in_decay  = {1'b0, since_reg} < decay_end;
    assign progress  = LEN_W'(since_reg - SINCE_W'(cfg.attack_length));

    // Release scaling: shift, saturate, then clear small levels.
    always_comb
    begin
        rel_shift = prod_reg >> L;
        if (rel_shift > PROD_W'(ENV_FULL))
        begin
            rel_level = ENV_FULL;
        end
        else
        begin
            rel_level = LEVEL_W'(rel_shift);
        end
        if (rel_level < ENV_CUTOFF)
        begin
            rel_level = '0;
        end
    end

    // One restoring division step.
    assign partial = {rem_reg, quo_reg[L-1]};
    assign diff    = {1'b0, partial} - {2'b00, div_d_reg};
    assign quo_ext = LEVEL_W'(quo_reg);

    // Input capture, classification, multiply and divider registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            since_reg <= since_start;
            until_reg <= until_release;
        end
        if (cmd.classify)
        begin
            if (releasing)
            begin
                phase_sel_reg <= PHASE_RELEASE;
                mul_a_reg     <= cur_level_reg;
                mul_b_reg     <= cfg.release_coefficient;
                div_d_reg     <= cfg.attack_length;
            end
            else if (in_attack)
            begin
                phase_sel_reg <= PHASE_ATTACK;
                mul_a_reg     <= LEVEL_W'(since_reg[LEN_W-1:0]);
                mul_b_reg     <= ENV_FULL - ENV_FLOOR;
                div_d_reg     <= cfg.attack_length;
            end
            else if (in_decay)
            begin
                phase_sel_reg <= PHASE_DECAY;
                mul_a_reg     <= LEVEL_W'(progress);
                mul_b_reg     <= ENV_FULL - sus_sat;
                div_d_reg     <= cfg.decay_length;
            end
            else
            begin
                phase_sel_reg <= PHASE_SUSTAIN;
                mul_a_reg     <= '0;
                mul_b_reg     <= '0;
                div_d_reg     <= cfg.decay_length;
            end
        end
        if (cmd.multiply)
        begin
            prod_reg <= PROD_W'(mul_a_reg) * PROD_W'(mul_b_reg);
        end
        if (cmd.div_init)
        begin
            // The quotient is known to stay below 2^L, so the top bits start as remainder.
            rem_reg <= prod_reg[L +: LEN_W];
            quo_reg <= prod_reg[L-1:0];
        end
        else if (cmd.div_step)
        begin
            if (!diff[LEN_W+1])
            begin
                rem_reg <= diff[LEN_W-1:0];
                quo_reg <= {quo_reg[L-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= partial[LEN_W-1:0];
                quo_reg <= {quo_reg[L-2:0], 1'b0};
            end
        end
    end

    // New envelope level for the finished transaction.
    always_comb
    begin
        cur_level_next = cur_level_reg;
        cur_phase_next = cur_phase_reg;
        if (cmd.finish)
        begin
            cur_phase_next = phase_sel_reg;
            case (phase_sel_reg)
                PHASE_RELEASE: cur_level_next = rel_level;
                PHASE_ATTACK:  cur_level_next = ENV_FLOOR + quo_ext;
                PHASE_DECAY:   cur_level_next = ENV_FULL - quo_ext;
                default:       cur_level_next = sus_sat;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_level_reg <= '0;
            cur_phase_reg <= PHASE_ATTACK;
        end
        else
        begin
            cur_level_reg <= cur_level_next;
            cur_phase_reg <= cur_phase_next;
        end
    end

    assign status.need_div = (phase_sel_reg == PHASE_ATTACK) || (phase_sel_reg == PHASE_DECAY);
    assign level = cur_level_reg;
    assign phase = cur_phase_reg;

endmodule

// ===== sv/adsr_envelope_generator_core.sv =====
// Top level of the ADSR envelope generator: configuration, controller and datapath.
//
// Each input transaction carries since_start and until_release for one audio sample
// and yields exactly one output transaction with the envelope level and its phase.
// Both channels use valid and stall; a transaction moves when valid is high and
// stall is low. Registers are written through cfg_we, cfg_index and cfg_data; the
// user must write them only while no transaction is in flight, which the block does
// not enforce. One transaction is processed at a time. Attack and decay samples
// pass through the restoring divider, which retires one quotient bit per cycle;
// release and sustain samples skip it. The result is loaded into the output register
// in the finish state, and a new input is taken as soon as it is loaded, even while
// that result still waits. If the receiver stalls with a result pending, the next
// result holds in the datapath and in_stall stays high until the output register
// frees. Reset clears the envelope level to zero, the phase to attack, empties the
// output register and restores the register defaults.
module adsr_envelope_generator_core
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = DEFAULT_LEVEL_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SINCE_W-1:0]    since_start,
    input  logic [UNTIL_W-1:0]    until_release,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LEVEL_W-1:0]    level,
    output logic [PHASE_W-1:0]    phase,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // Register bank.
    adsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer.
    adsr_ctrl #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and envelope state.
    adsr_dp #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .since_start   (since_start),
        .until_release (until_release),
        .level         (level),
        .phase         (phase)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the ADSR envelope generator core.
`timescale 1ns / 1ps

module tb;
    import adsr_pkg::*;

    localparam int FRAC_BITS = DEFAULT_LEVEL_FRAC_BITS;
    localparam logic [63:0] FULL_SCALE = (64'd1 << FRAC_BITS) - 64'd1;
    localparam int DRAIN_CYCLES = 50;

    // One expected output transaction.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        phase_t             phase;
    } envelope_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SINCE_W-1:0]    since_start = '0;
    logic [UNTIL_W-1:0]    until_release = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [LEVEL_W-1:0]    level;
    logic [PHASE_W-1:0]    phase;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copies and envelope state of the predictor.
    logic [LEN_W-1:0]   atk_len   = ATTACK_RESET;
    logic [LEN_W-1:0]   dec_len   = DECAY_RESET;
    logic [LEVEL_W-1:0] sus_lvl   = SUSTAIN_RESET;
    logic [LEVEL_W-1:0] rel_coef  = RELEASE_RESET;
    logic [LEVEL_W-1:0] env_level = '0;

    envelope_t expected_envelopes[$];

    bit idle_en = 1'b1;
    int stall_left = 0;
    int errors = 0;
    int samples_sent = 0;
    int levels_checked = 0;
    int register_writes = 0;
    int phase_seen[4] = '{0, 0, 0, 0};

    adsr_envelope_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .since_start   (since_start),
        .until_release (until_release),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .level         (level),
        .phase         (phase),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

    // Envelope level and phase for one sample, from the current state and registers.
    function automatic envelope_t compute_envelope(input logic [31:0] s, input logic [31:0] u);
        logic [63:0] scaled;
        logic [63:0] span;
        logic [63:0] sus;
        envelope_t   r;
        sus = (64'(sus_lvl) > FULL_SCALE) ? FULL_SCALE : 64'(sus_lvl);
        if (u == '0 || u[31])
        begin
            scaled = (64'(env_level) * 64'(rel_coef)) >> FRAC_BITS;
            if (scaled > FULL_SCALE)
                scaled = FULL_SCALE;
            if (scaled < 64'(ENV_CUTOFF))
                scaled = '0;
            r.level = scaled[LEVEL_W-1:0];
            r.phase = PHASE_RELEASE;
        end
        else if (64'(s) < 64'(atk_len))
        begin
            span = FULL_SCALE - 64'(ENV_FLOOR);
            scaled = 64'(ENV_FLOOR) + (64'(s) * span) / 64'(atk_len);
            r.level = scaled[LEVEL_W-1:0];
            r.phase = PHASE_ATTACK;
        end
        else if (64'(s) < 64'(atk_len) + 64'(dec_len))
        begin
            span = FULL_SCALE - sus;
            scaled = FULL_SCALE - ((64'(s) - 64'(atk_len)) * span) / 64'(dec_len);
            r.level = scaled[LEVEL_W-1:0];
            r.phase = PHASE_DECAY;
        end
        else
        begin
            r.level = sus[LEVEL_W-1:0];
            r.phase = PHASE_SUSTAIN;
        end
        return r;
    endfunction

    // Send one sample; the expectation is queued when the transaction is accepted.
    task automatic send_sample(input logic [31:0] s, input logic [31:0] u);
        envelope_t r;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        since_start   <= s;
        until_release <= u;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        r = compute_envelope(s, u);
        env_level = r.level;
        expected_envelopes.push_back(r);
        samples_sent++;
    endtask

    // Stop sending and wait until every expected level has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_envelopes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register while the block is idle and mirror it in the predictor.
    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ATTACK_LENGTH:       atk_len  = value[LEN_W-1:0];
            CFG_DECAY_LENGTH:        dec_len  = value[LEN_W-1:0];
            CFG_SUSTAIN_LEVEL:       sus_lvl  = value[LEVEL_W-1:0];
            CFG_RELEASE_COEFFICIENT: rel_coef = value[LEVEL_W-1:0];
            default: ;
        endcase
        register_writes++;
        @(posedge clk);
    endtask

    // Compare each accepted result with the oldest expectation and drive receiver stalls.
    initial
    begin
        envelope_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_envelopes.size() == 0)
                begin
                    $error("unexpected transaction: level %h phase %0d", level, phase);
                    errors++;
                end
                else
                begin
                    want = expected_envelopes.pop_front();
                    if (level !== want.level)
                    begin
                        $error("level mismatch: expected %h, actual %h", want.level, level);
                        errors++;
                    end
                    if (phase !== want.phase)
                    begin
                        $error("phase mismatch: expected %0d, actual %0d", want.phase, phase);
                        errors++;
                    end
                    phase_seen[want.phase]++;
                    levels_checked++;
                end
            end
            // Receiver stalls come in short bursts.
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Ramp boundaries and release with the register values after reset.
    task automatic test_reset_defaults();
        send_sample(32'd0, 32'd1);
        send_sample(32'd479, 32'h7FFF_FFFF);
        send_sample(32'd480, 32'd5);
        send_sample(32'd5279, 32'd5);
        send_sample(32'd5280, 32'd5);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'd100, 32'd0);
        send_sample(32'd100, 32'h8000_0000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Zero-length attack and decay skip their ramps; upper data bits are dropped.
    task automatic test_zero_lengths();
        write_register(CFG_ATTACK_LENGTH, '0);
        write_register(CFG_DECAY_LENGTH, '0);
        send_sample(32'd0, 32'd1);
        write_register(CFG_DECAY_LENGTH, 31'd7);
        send_sample(32'd0, 32'd1);
        send_sample(32'd6, 32'd1);
        send_sample(32'd7, 32'd1);
        write_register(CFG_ATTACK_LENGTH, 31'h7F00_0003);
        send_sample(32'd2, 32'd1);
    endtask

    // Longest ramps, where the end of decay needs the 25-bit sum.
    task automatic test_long_ramps();
        write_register(CFG_ATTACK_LENGTH, 31'h00FF_FFFF);
        write_register(CFG_DECAY_LENGTH, 31'h00FF_FFFF);
        send_sample(32'h00FF_FFFE, 32'd1);
        send_sample(32'h00FF_FFFF, 32'd1);
        send_sample(32'h01FF_FFFD, 32'd1);
        send_sample(32'h01FF_FFFE, 32'd1);
    endtask

    // Release around the cutoff, from full scale and from a level already zero.
    task automatic test_release_floor();
        write_register(CFG_ATTACK_LENGTH, '0);
        write_register(CFG_DECAY_LENGTH, '0);
        write_register(CFG_SUSTAIN_LEVEL, 31'h0000_0401);
        write_register(CFG_RELEASE_COEFFICIENT, 31'h7FFF_FFFF);
        send_sample(32'd0, 32'd1);
        send_sample(32'd0, 32'd0);
        send_sample(32'd0, 32'd0);
        send_sample(32'd0, 32'hFFFF_FFFF);
        write_register(CFG_SUSTAIN_LEVEL, 31'h7FFF_FFFF);
        send_sample(32'd0, 32'd1);
        write_register(CFG_RELEASE_COEFFICIENT, '0);
        send_sample(32'd0, 32'd0);
        write_register(CFG_SUSTAIN_LEVEL, '0);
        send_sample(32'd0, 32'd1);
    endtask

    // Random ramp length, mostly short so that a note passes every phase.
    function automatic logic [CFG_DATA_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 31'h00FF_FFFF;
            2:       return 31'($urandom_range(0, 24'hFF_FFFF));
            default: return 31'($urandom_range(1, 40));
        endcase
    endfunction

    // Rewrite a random subset of the registers.
    task automatic shuffle_settings();
        if ($urandom_range(0, 1) == 0)
            write_register(CFG_ATTACK_LENGTH, pick_length());
        if ($urandom_range(0, 1) == 0)
            write_register(CFG_DECAY_LENGTH, pick_length());
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 5))
                0:       write_register(CFG_SUSTAIN_LEVEL, '0);
                1:       write_register(CFG_SUSTAIN_LEVEL, 31'h7FFF_FFFF);
                default: write_register(CFG_SUSTAIN_LEVEL, 31'($urandom()));
            endcase
        end
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 7))
                0:       write_register(CFG_RELEASE_COEFFICIENT, '0);
                1:       write_register(CFG_RELEASE_COEFFICIENT, 31'h7FFF_FFFF);
                2:       write_register(CFG_RELEASE_COEFFICIENT, 31'($urandom()));
                default: write_register(CFG_RELEASE_COEFFICIENT,
                                        31'($urandom_range(32'h6000_0000, 32'h7FFF_FFFF)));
            endcase
        end
    endtask

    // One note: counting samples through hold and release, with some stray samples.
    task automatic run_note();
        int unsigned hold_len;
        int unsigned rel_len;
        int unsigned first;
        int          i;
        hold_len = $urandom_range(0, 60);
        rel_len  = $urandom_range(1, 35);
        if ($urandom_range(0, 3) == 0)
            first = $urandom_range(0, int'(atk_len) + int'(dec_len));
        else
            first = 0;
        for (i = 0; i < int'(hold_len + rel_len); i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample($urandom(), $urandom());
            else
                send_sample(32'(first + i), 32'(int'(hold_len) - i));
        end
    endtask

    // Notes under changing settings until the sample count reaches the target.
    task automatic test_random_notes(input int target);
        while (samples_sent < target)
        begin
            if ($urandom_range(0, 2) == 0)
                shuffle_settings();
            run_note();
        end
    endtask

    // Same traffic at full rate on both sides.
    task automatic test_steady_notes(input int target);
        idle_en = 1'b0;
        test_random_notes(target);
    endtask

    // Test sequence.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zero_lengths();
        test_long_ramps();
        test_release_floor();
        test_random_notes(650);
        test_steady_notes(820);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d samples sent, %0d levels checked, %0d register writes",
                 samples_sent, levels_checked, register_writes);
        $display("summary: attack %0d, decay %0d, sustain %0d, release %0d",
                 phase_seen[PHASE_ATTACK], phase_seen[PHASE_DECAY],
                 phase_seen[PHASE_SUSTAIN], phase_seen[PHASE_RELEASE]);
        if (errors == 0 && expected_envelopes.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/adsr_pkg.sv
sv/adsr_cfg.sv
sv/adsr_ctrl.sv
sv/adsr_dp.sv
sv/adsr_envelope_generator_core.sv
bench/tb.sv
